[design/b64d_pkg.sv]
`timescale 1ns / 1ps

package b64d_pkg;

	localparam int unsigned NumRegs = 2;
	localparam int unsigned RegIdxW = $clog2(NumRegs);
	localparam int unsigned RegDataW = 1;

	localparam logic [RegIdxW-1:0] REG_BOUNDARY_MODE = RegIdxW'(0);
	localparam logic [RegIdxW-1:0] REG_URL_ALPHABET  = RegIdxW'(1);

	localparam logic [7:0] CH_PAD   = 8'h3d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_BOUNDARY  = 3'd1,
		ST_ERROR     = 3'd2,
		ST_FIN_OK    = 3'd3,
		ST_FIN_FAIL  = 3'd4
	} status_t;

	typedef enum logic {
		REQ_CHAR   = 1'b0,
		REQ_FINISH = 1'b1
	} req_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [5:0] held_bits;
		logic       padding_seen;
		logic       end_seen;
		logic       boundary_seen;
		logic       error_flag;
	} dec_state_t;

	typedef struct packed {
		logic boundary_mode;
		logic url_alphabet;
	} dec_cfg_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic [2:0] status;
	} dec_result_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c, input logic url);
		sextet_t s;
		s.hit = 1'b1;
		s.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			s.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (url && c == 8'h2d) begin
			s.value = 6'h3e;
		end else if (url && c == 8'h5f) begin
			s.value = 6'h3f;
		end else if (!url && c == 8'h2b) begin
			s.value = 6'h3e;
		end else if (!url && c == 8'h2f) begin
			s.value = 6'h3f;
		end else begin
			s.hit = 1'b0;
		end
		return s;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE) || (c == CH_TAB);
	endfunction

endpackage

[design/b64d_if.sv]
`timescale 1ns / 1ps

interface b64d_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_byte;

	modport source (output valid, output req_type, output in_byte, input ready);
	modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface b64d_res_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic [2:0] status;

	modport source (output valid, output out_valid, output out_byte, output status,
		input ready);
	modport sink (input valid, input out_valid, input out_byte, input status,
		output ready);
endinterface

[design/base64_stream_decoder.sv]
`timescale 1ns / 1ps
// An accepted transaction's result is registered and is on res_ch the next cycle.
// Throughput: one character or finish transaction per cycle unless res_ch stalls,
// set by the single alphabet lookup and phase update before the result register.
// Reset (arst_n low): decoder state and both configuration registers cleared,
// result register empty.

module base64_stream_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	b64d_req_if.sink                      req_ch,
	b64d_res_if.source                    res_ch,
	input  logic                          wr_en,
	input  logic [b64d_pkg::RegIdxW-1:0]  wr_index,
	input  logic [b64d_pkg::RegDataW-1:0] wr_data
);
	import b64d_pkg::*;

	dec_cfg_t    cfg_q;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res_nxt;
	dec_result_t res_q;
	logic        res_vld_q;
	logic        in_fire;

	assign req_ch.ready = !res_vld_q || res_ch.ready;
	assign in_fire      = req_ch.valid && req_ch.ready;

	b64d_core u_core (
		.state     (state_q),
		.cfg       (cfg_q),
		.req_type  (req_ch.req_type),
		.in_byte   (req_ch.in_byte),
		.state_nxt (state_nxt),
		.result    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BOUNDARY_MODE: cfg_q.boundary_mode <= wr_data[0];
				REG_URL_ALPHABET:  cfg_q.url_alphabet  <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q   <= state_nxt;
				res_vld_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_nxt;
		end
	end

	assign res_ch.valid     = res_vld_q;
	assign res_ch.out_valid = res_q.out_valid;
	assign res_ch.out_byte  = res_q.out_byte;
	assign res_ch.status    = res_q.status;

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && req_ch.req_type == REQ_FINISH |=> state_q == '0)
		else $error("finish did not clear decoder state");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.error_flag && !(in_fire && req_ch.req_type == REQ_FINISH)
		|=> state_q.error_flag)
		else $error("error flag dropped without finish");

	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.out_valid |-> res_q.status == ST_ACCEPTED)
		else $error("data byte with non-accepted status");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> res_vld_q)
		else $error("accepted transaction produced no result");

endmodule

[design/b64d_core.sv]
`timescale 1ns / 1ps

module b64d_core (
	input  b64d_pkg::dec_state_t  state,
	input  b64d_pkg::dec_cfg_t    cfg,
	input  logic                  req_type,
	input  logic [7:0]            in_byte,
	output b64d_pkg::dec_state_t  state_nxt,
	output b64d_pkg::dec_result_t result
);
	import b64d_pkg::*;

	sextet_t sx;
	logic    blank;
	logic    pad;

	assign sx    = sextet_of(in_byte, cfg.url_alphabet);
	assign blank = is_blank(in_byte);
	assign pad   = (in_byte == CH_PAD);

	always_comb begin
		state_nxt        = state;
		result.out_valid = 1'b0;
		result.out_byte  = 8'd0;
		result.status    = ST_ACCEPTED;

		if (req_type == REQ_FINISH) begin
			result.status = (!state.error_flag && state.phase == 2'd0) ? ST_FIN_OK : ST_FIN_FAIL;
			state_nxt = '0;
		end else if (state.error_flag) begin
			result.status = ST_ERROR;
		end else if (state.boundary_seen) begin
			state_nxt.error_flag = 1'b1;
			result.status = ST_ERROR;
		end else if (state.end_seen || (state.padding_seen && !pad) ||
				(!state.padding_seen && !sx.hit && !blank &&
				 !(pad && (state.phase == 2'd2 || state.phase == 2'd3)))) begin
			// reject: anything but whitespace here ends the stream
			if (!blank) begin
				if (cfg.boundary_mode) begin
					state_nxt.boundary_seen = 1'b1;
					result.status = ST_BOUNDARY;
				end else begin
					state_nxt.error_flag = 1'b1;
					result.status = ST_ERROR;
				end
			end
		end else if (state.padding_seen || (pad && state.phase == 2'd3)) begin
			state_nxt.padding_seen = 1'b1;
			state_nxt.end_seen     = 1'b1;
			state_nxt.phase        = 2'd0;
			state_nxt.held_bits    = 6'd0;
		end else if (pad) begin
			state_nxt.padding_seen = 1'b1;
			state_nxt.phase        = 2'd3;
		end else if (sx.hit) begin
			state_nxt.held_bits = sx.value;
			state_nxt.phase     = state.phase + 2'd1;
			case (state.phase)
				2'd0: begin
				end
				2'd1: begin
					result.out_valid = 1'b1;
					result.out_byte  = {state.held_bits, sx.value[5:4]};
				end
				2'd2: begin
					result.out_valid = 1'b1;
					result.out_byte  = {state.held_bits[3:0], sx.value[5:2]};
				end
				default: begin
					result.out_valid    = 1'b1;
					result.out_byte     = {state.held_bits[1:0], sx.value};
					state_nxt.held_bits = 6'd0;
				end
			endcase
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import b64d_pkg::*;

	localparam int unsigned RandomItems = 1950;
	localparam int unsigned PhaseItems = 330;
	localparam int unsigned StallLimit = 1000;
	localparam int unsigned ReportLimit = 10;
	localparam dec_cfg_t CfgPlain = '{boundary_mode: 1'b0, url_alphabet: 1'b0};
	localparam dec_cfg_t CfgUrlBoundary = '{boundary_mode: 1'b1, url_alphabet: 1'b1};

	typedef struct {
		dec_cfg_t    cfg;
		req_t        kind;
		logic [7:0]  ch;
		bit          typed;
		dec_result_t want;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                wr_en;
	logic [RegIdxW-1:0]  wr_index;
	logic [RegDataW-1:0] wr_data;

	b64d_req_if req_ch();
	b64d_res_if res_ch();

	dec_state_t  model_st;
	dec_cfg_t    model_cfg;
	dec_result_t awaited[$];
	script_row_t script[$];
	int unsigned sent_items;
	int unsigned mismatches;
	int unsigned stall_cycles;
	bit          calm;

	base64_stream_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_ch   (req_ch),
		.res_ch   (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= calm || ($urandom_range(99) >= 16);
		end
	end

	function automatic string alphabet_text(input logic url);
		string head;
		head = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
		return url ? {head, "-_"} : {head, "+/"};
	endfunction

	function automatic int sextet_lookup(input logic [7:0] ch, input logic url);
		string digits;
		digits = alphabet_text(url);
		for (int k = 0; k < 64; k++) begin
			if (digits[k] == ch) begin
				return k;
			end
		end
		return -1;
	endfunction

	function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
		string digits;
		digits = alphabet_text(url);
		return digits[v];
	endfunction

	function automatic bit blank_char(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic status_t reject_char();
		if (model_cfg.boundary_mode) begin
			model_st.boundary_seen = 1'b1;
			return ST_BOUNDARY;
		end
		model_st.error_flag = 1'b1;
		return ST_ERROR;
	endfunction

	function automatic dec_result_t decode_step(input req_t kind, input logic [7:0] ch);
		dec_result_t r;
		int          sx;
		logic [5:0]  s;
		r = '{out_valid: 1'b0, out_byte: 8'h00, status: ST_ACCEPTED};
		if (kind == REQ_FINISH) begin
			r.status = (!model_st.error_flag && model_st.phase == 2'd0) ? ST_FIN_OK : ST_FIN_FAIL;
			model_st = '0;
		end else if (model_st.error_flag) begin
			r.status = ST_ERROR;
		end else if (model_st.boundary_seen) begin
			model_st.error_flag = 1'b1;
			r.status = ST_ERROR;
		end else if (model_st.end_seen) begin
			if (!blank_char(ch)) begin
				r.status = reject_char();
			end
		end else if (model_st.padding_seen) begin
			if (ch == CH_PAD) begin
				model_st.end_seen = 1'b1;
				model_st.phase = 2'd0;
				model_st.held_bits = 6'd0;
			end else if (!blank_char(ch)) begin
				r.status = reject_char();
			end
		end else begin
			sx = sextet_lookup(ch, model_cfg.url_alphabet);
			s = 6'(sx);
			if (sx >= 0) begin
				r.out_valid = model_st.phase != 2'd0;
				case (model_st.phase)
					2'd0: r.out_byte = 8'h00;
					2'd1: r.out_byte = {model_st.held_bits, s[5:4]};
					2'd2: r.out_byte = {model_st.held_bits[3:0], s[5:2]};
					default: r.out_byte = {model_st.held_bits[1:0], s};
				endcase
				model_st.held_bits = (model_st.phase == 2'd3) ? 6'd0 : s;
				model_st.phase = model_st.phase + 2'd1;
			end else if (!blank_char(ch)) begin
				if (ch == CH_PAD && model_st.phase == 2'd2) begin
					model_st.padding_seen = 1'b1;
					model_st.phase = 2'd3;
				end else if (ch == CH_PAD && model_st.phase == 2'd3) begin
					model_st.padding_seen = 1'b1;
					model_st.end_seen = 1'b1;
					model_st.phase = 2'd0;
					model_st.held_bits = 6'd0;
				end else begin
					r.status = reject_char();
				end
			end
		end
		return r;
	endfunction

	task automatic send_item(input req_t kind, input logic [7:0] ch, input bit typed = 1'b0,
			input dec_result_t want = '0);
		dec_result_t predicted;
		bit          taken;
		while (!calm && $urandom_range(99) < 16) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.in_byte <= ch;
		do begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end while (!taken);
		predicted = decode_step(kind, ch);
		awaited.push_back(typed ? want : predicted);
		sent_items++;
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited.size() != 0);
	endtask

	task automatic apply_cfg(input dec_cfg_t c);
		hold_until_drained();
		repeat (2) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_BOUNDARY_MODE;
		wr_data <= c.boundary_mode;
		@(posedge clk);
		wr_index <= REG_URL_ALPHABET;
		wr_data <= c.url_alphabet;
		@(posedge clk);
		wr_en <= 1'b0;
		model_cfg = c;
	endtask

	task automatic send_text_char(input logic [7:0] ch, input bit noisy);
		string       odd;
		logic [7:0]  sent;
		odd = "+/-_=";
		sent = ch;
		if ($urandom_range(99) < 8) begin
			send_item(REQ_CHAR, random_blank());
		end
		if (noisy && $urandom_range(99) < 8) begin
			sent = ($urandom_range(1) == 0) ? odd[$urandom_range(4)] : 8'($urandom_range(255));
		end
		send_item(REQ_CHAR, sent);
	endtask

	task automatic send_random_stream();
		logic [7:0]  data[$];
		logic [23:0] grp;
		int          n, chars, pads, shape;
		bit          noisy, broken;
		shape = $urandom_range(99);
		noisy = shape >= 70 && shape < 88;
		broken = shape >= 88;
		n = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(10);
		for (int k = 0; k < n; k++) begin
			data.push_back(8'($urandom_range(255)));
		end
		for (int k = 0; k < n; k += 3) begin
			grp = {data[k], (k + 1 < n) ? data[k+1] : 8'h00, (k + 2 < n) ? data[k+2] : 8'h00};
			chars = (n - k >= 3) ? 4 : n - k + 1;
			pads = 4 - chars;
			if (broken && $urandom_range(3) == 0) begin
				chars--;
			end
			for (int j = 0; j < chars; j++) begin
				send_text_char(sextet_char(grp[23-6*j -: 6], model_cfg.url_alphabet), noisy);
			end
			if (broken && $urandom_range(1) == 0) begin
				pads = $urandom_range(3);
			end
			for (int j = 0; j < pads; j++) begin
				send_text_char(CH_PAD, noisy);
			end
		end
		if ($urandom_range(3) == 0) begin
			send_item(REQ_CHAR, random_blank());
		end
		if ($urandom_range(4) == 0) begin
			send_item(REQ_CHAR, 8'($urandom_range(255)));
		end
		if ($urandom_range(9) != 0) begin
			send_item(REQ_FINISH, 8'($urandom_range(255)));
		end
	endtask

	task automatic check_result();
		dec_result_t got, want;
		got = '{res_ch.out_valid, res_ch.out_byte, res_ch.status};
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= ReportLimit) begin
				$display("%0t: unexpected transaction valid=%0b byte=%02h status=%0d",
					$realtime, got.out_valid, got.out_byte, got.status);
			end
			return;
		end
		want = awaited.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= ReportLimit) begin
				$display("%0t: exp valid=%0b byte=%02h status=%0d, got valid=%0b byte=%02h status=%0d",
					$realtime, want.out_valid, want.out_byte, want.status,
					got.out_valid, got.out_byte, got.status);
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			check_result();
		end
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= StallLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void add_row(input dec_cfg_t cfg, input req_t kind, input logic [7:0] ch,
			input bit typed = 1'b0, input dec_result_t want = '0);
		script.push_back('{cfg: cfg, kind: kind, ch: ch, typed: typed, want: want});
	endfunction

	initial begin
		dec_cfg_t    cfg;
		int unsigned phase_no, quota, pause_at;
		bit          paused;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_CHAR;
		req_ch.in_byte <= 8'h00;
		mismatches = 0;
		sent_items = 0;
		calm = 1'b0;
		model_st = '0;
		model_cfg = CfgPlain;

		add_row(CfgPlain, REQ_FINISH, 8'h00, 1'b1, '{1'b0, 8'h00, ST_FIN_OK});
		add_row(CfgPlain, REQ_CHAR, "T", 1'b1, '{1'b0, 8'h00, ST_ACCEPTED});
		add_row(CfgPlain, REQ_CHAR, "W", 1'b1, '{1'b1, 8'h4d, ST_ACCEPTED});
		add_row(CfgPlain, REQ_CHAR, "F", 1'b1, '{1'b1, 8'h61, ST_ACCEPTED});
		add_row(CfgPlain, REQ_CHAR, "u", 1'b1, '{1'b1, 8'h6e, ST_ACCEPTED});
		add_row(CfgPlain, REQ_CHAR, CH_SPACE, 1'b1, '{1'b0, 8'h00, ST_ACCEPTED});
		add_row(CfgPlain, REQ_CHAR, "+");
		add_row(CfgPlain, REQ_CHAR, "/");
		add_row(CfgPlain, REQ_CHAR, CH_PAD);
		add_row(CfgPlain, REQ_CHAR, CH_TAB);
		add_row(CfgPlain, REQ_CHAR, CH_PAD);
		add_row(CfgPlain, REQ_CHAR, "A", 1'b1, '{1'b0, 8'h00, ST_ERROR});
		add_row(CfgPlain, REQ_CHAR, 8'hff, 1'b1, '{1'b0, 8'h00, ST_ERROR});
		add_row(CfgPlain, REQ_FINISH, 8'hff, 1'b1, '{1'b0, 8'h00, ST_FIN_FAIL});
		add_row(CfgPlain, REQ_CHAR, CH_PAD, 1'b1, '{1'b0, 8'h00, ST_ERROR});
		add_row(CfgPlain, REQ_CHAR, 8'h00, 1'b1, '{1'b0, 8'h00, ST_ERROR});
		add_row(CfgPlain, REQ_FINISH, 8'h00, 1'b1, '{1'b0, 8'h00, ST_FIN_FAIL});
		add_row(CfgPlain, REQ_CHAR, "z");
		add_row(CfgPlain, REQ_CHAR, "9");
		add_row(CfgPlain, REQ_CHAR, "A");
		add_row(CfgPlain, REQ_CHAR, CH_PAD);
		add_row(CfgPlain, REQ_CHAR, CH_CR);
		add_row(CfgPlain, REQ_FINISH, 8'h00, 1'b1, '{1'b0, 8'h00, ST_FIN_OK});
		add_row(CfgUrlBoundary, REQ_CHAR, "-");
		add_row(CfgUrlBoundary, REQ_CHAR, "_");
		add_row(CfgUrlBoundary, REQ_CHAR, "+", 1'b1, '{1'b0, 8'h00, ST_BOUNDARY});
		add_row(CfgUrlBoundary, REQ_CHAR, "A", 1'b1, '{1'b0, 8'h00, ST_ERROR});
		add_row(CfgUrlBoundary, REQ_FINISH, 8'h00, 1'b1, '{1'b0, 8'h00, ST_FIN_FAIL});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].cfg != model_cfg) begin
				apply_cfg(script[i].cfg);
			end
			send_item(script[i].kind, script[i].ch, script[i].typed, script[i].want);
		end

		phase_no = 0;
		while (sent_items < script.size() + RandomItems) begin
			case (phase_no)
				0: cfg = '{boundary_mode: 1'b0, url_alphabet: 1'b1};
				1: cfg = '{boundary_mode: 1'b1, url_alphabet: 1'b0};
				2: cfg = CfgUrlBoundary;
				3: cfg = CfgPlain;
				default: cfg = dec_cfg_t'(2'($urandom_range(3)));
			endcase
			apply_cfg(cfg);
			calm = phase_no == 1;
			quota = sent_items + PhaseItems;
			pause_at = sent_items + $urandom_range(40, 250);
			paused = 1'b0;
			while (sent_items < quota) begin
				send_random_stream();
				if (!paused && sent_items >= pause_at) begin
					hold_until_drained();
					paused = 1'b1;
				end
			end
			phase_no++;
		end
		calm = 1'b0;

		hold_until_drained();
		repeat (5) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[filelist.f]
design/b64d_pkg.sv
design/b64d_if.sv
design/b64d_core.sv
design/base64_stream_decoder.sv
tb/tb_top.sv
